// ===== hw/rtl/vmb_pkg.sv =====
// Shared types and constants for the vertical motion blur block.
// No dependencies.
`default_nettype none
package vmb_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_BLUR    = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int PTR_W       = $clog2(MAX_BLUR);
  localparam int BLUR_W      = $clog2(MAX_BLUR + 1);
  localparam int WIDTH_REG_W = 11;
  localparam int BLUR_REG_W  = 5;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int PIX_W       = NUM_CH * CH_W;
  localparam int SUM_W       = 16;
  localparam int SUMS_W      = NUM_CH * SUM_W;
  localparam int HIST_AW     = PTR_W + COL_W;
  localparam int HIST_DEPTH  = MAX_BLUR * MAX_WIDTH;
  localparam int TQ_DEPTH    = 4;
  localparam int TQ_AW       = $clog2(TQ_DEPTH);
  localparam int OQ_DEPTH    = 2;
  localparam int OQ_AW       = $clog2(OQ_DEPTH);
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [APB_AW-3:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [APB_AW-3:0] REG_BLUR_AMOUNT = 1'd1;

  localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RST = 11'd1024;
  localparam logic [BLUR_REG_W-1:0]  BLUR_AMOUNT_RST = 5'd4;

  typedef struct packed {
    logic            frame_start;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } out_item_t;

  // one classified pixel: where it sits in the window and its colour
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [PTR_W-1:0]  ptr;
    logic [BLUR_W-1:0] rows;
    logic              full_win;
    logic [PIX_W-1:0]  pix;
  } task_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_WRITE
  } back_state_e;

endpackage
`default_nettype wire

// ===== hw/rtl/vmb_front.sv =====
// Front end: frame position counters, classifies each accepted pixel.
// Depends on vmb_pkg.
`default_nettype none
module vmb_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  vmb_pkg::in_item_t                 pixel,
  input  logic [vmb_pkg::WIDTH_REG_W-1:0]   image_width,
  input  logic [vmb_pkg::BLUR_REG_W-1:0]    blur_amount,
  output vmb_pkg::task_t                    task_item
);
  import vmb_pkg::*;

  logic [COL_W-1:0]       col, col_next;
  logic [PTR_W-1:0]       ptr, ptr_next;
  logic [BLUR_W-1:0]      rows, rows_next;
  logic [WIDTH_REG_W-1:0] w_eff;
  logic [BLUR_W-1:0]      b_eff;
  logic [COL_W-1:0]       ci;
  logic [PTR_W-1:0]       hp0, hp;
  logic [BLUR_W-1:0]      rs0, rs;
  logic                   last;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_REG_W'(1);
    end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (blur_amount == '0) begin
      b_eff = BLUR_W'(1);
    end else if (BLUR_W'(blur_amount) > BLUR_W'(MAX_BLUR)) begin
      b_eff = BLUR_W'(MAX_BLUR);
    end else begin
      b_eff = BLUR_W'(blur_amount);
    end

    ci  = pixel.frame_start ? '0 : col;
    rs0 = pixel.frame_start ? '0 : rows;
    hp0 = pixel.frame_start ? '0 : ptr;
    rs  = (rs0 > b_eff) ? b_eff : rs0;
    hp  = (BLUR_W'(hp0) >= b_eff) ? '0 : hp0;
    last = (WIDTH_REG_W'(ci) + WIDTH_REG_W'(1)) >= w_eff;

    col_next  = col;
    ptr_next  = ptr;
    rows_next = rows;
    if (take) begin
      if (last) begin
        col_next  = '0;
        ptr_next  = ((BLUR_W'(hp) + BLUR_W'(1)) >= b_eff) ? '0 : PTR_W'(hp + PTR_W'(1));
        rows_next = (rs < b_eff) ? BLUR_W'(rs + BLUR_W'(1)) : rs;
      end else begin
        col_next  = COL_W'(ci + COL_W'(1));
        ptr_next  = hp;
        rows_next = rs;
      end
    end

    task_item.col      = ci;
    task_item.ptr      = hp;
    task_item.rows     = rs;
    task_item.full_win = (rs == b_eff);
    task_item.pix      = {pixel.red_in, pixel.green_in, pixel.blue_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      ptr  <= '0;
      rows <= '0;
    end else begin
      col  <= col_next;
      ptr  <= ptr_next;
      rows <= rows_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vmb_taskq.sv =====
// Short queue of classified pixels between front and back end.
// Depends on vmb_pkg.
`default_nettype none
module vmb_taskq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vmb_pkg::task_t  wr_data,
  input  logic            pop,
  output vmb_pkg::task_t  rd_data,
  output logic            full,
  output logic            empty
);
  import vmb_pkg::*;

  task_t             slots [TQ_DEPTH];
  logic [TQ_AW-1:0]  wr_ptr, rd_ptr;
  logic [TQ_AW:0]    count;
  logic              do_push, do_pop;

  assign full    = (count == (TQ_AW+1)'(TQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= TQ_AW'(wr_ptr + TQ_AW'(1));
      if (do_pop)  rd_ptr <= TQ_AW'(rd_ptr + TQ_AW'(1));
      count <= (TQ_AW+1)'(count + (TQ_AW+1)'(do_push) - (TQ_AW+1)'(do_pop));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (TQ_AW+1)'(TQ_DEPTH))
    else $error("task queue count overflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + (TQ_AW+1)'(1))
    else $error("task queue count lost a push");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    empty |-> wr_ptr == rd_ptr)
    else $error("task queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== hw/rtl/vmb_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on vmb_pkg.
`default_nettype none
module vmb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [vmb_pkg::SUM_W-1:0]   dividend,
  input  logic [vmb_pkg::BLUR_W-1:0]  divisor,
  output logic [vmb_pkg::SUM_W-1:0]   quotient,
  output logic                        busy
);
  import vmb_pkg::*;

  logic [SUM_W-1:0]     dq;
  logic [BLUR_W-1:0]    rem, dvs;
  logic [BLUR_W:0]      rem_sh;
  logic                 ge;
  logic [DIV_CNT_W-1:0] cnt;

  assign rem_sh   = {rem, dq[SUM_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[SUM_W-2:0], ge};
      rem <= ge ? BLUR_W'(rem_sh - {1'b0, dvs}) : rem_sh[BLUR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
    end else if (start) begin
      cnt  <= DIV_CNT_W'(SUM_W);
      busy <= 1'b1;
    end else if (busy) begin
      cnt  <= DIV_CNT_W'(cnt - DIV_CNT_W'(1));
      busy <= (cnt != DIV_CNT_W'(1));
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vmb_back.sv =====
// Back end: line history and column sum memories, per-channel dividers,
// result queue. Depends on vmb_pkg and vmb_div.
`default_nettype none
module vmb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               tq_empty,
  input  vmb_pkg::task_t     tq_data,
  output logic               tq_pop,
  input  logic               pop,
  output logic               empty,
  output vmb_pkg::out_item_t pixel_out
);
  import vmb_pkg::*;

  back_state_e        state, state_next;
  logic [PIX_W-1:0]   hist [HIST_DEPTH];
  logic [SUMS_W-1:0]  sums [MAX_WIDTH];
  task_t              cur;
  logic [PIX_W-1:0]   hist_rd;
  logic [SUMS_W-1:0]  sum_rd;
  logic               div_start;
  logic [SUM_W-1:0]   quo [NUM_CH];
  logic [NUM_CH-1:0]  div_busy;
  logic               res_push;
  logic [SUMS_W-1:0]  sum_new;
  out_item_t          res;
  logic [CH_W-1:0]    res_ch [NUM_CH];

  out_item_t          oq [OQ_DEPTH];
  logic [OQ_AW-1:0]   oq_wr, oq_rd;
  logic [OQ_AW:0]     oq_count;
  logic               oq_space, oq_pop;

  assign oq_space = oq_count < (OQ_AW+1)'(OQ_DEPTH);

  always_comb begin
    state_next = state;
    tq_pop     = 1'b0;
    div_start  = 1'b0;
    res_push   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!tq_empty && oq_space) begin
          tq_pop     = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_busy == '0) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        res_push   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tq_pop) begin
      cur     <= tq_data;
      hist_rd <= hist[{tq_data.ptr, tq_data.col}];
      sum_rd  <= sums[tq_data.col];
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_div
    vmb_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (sum_rd[(NUM_CH-1-g)*SUM_W +: SUM_W]),
      .divisor  (cur.rows),
      .quotient (quo[g]),
      .busy     (div_busy[g])
    );
  end

  // channel 0 is red, held in the top bits of both stores
  always_comb begin
    logic [CH_W-1:0]  px;
    logic [CH_W-1:0]  old;
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] r;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      px = cur.pix[(NUM_CH-1-ch)*CH_W +: CH_W];
      old = hist_rd[(NUM_CH-1-ch)*CH_W +: CH_W];
      s  = sum_rd[(NUM_CH-1-ch)*SUM_W +: SUM_W];
      r  = SUM_W'(px >> 1);
      if (cur.rows != '0) r = SUM_W'(r + (quo[ch] >> 1));
      res_ch[ch] = (r > SUM_W'(255)) ? CH_W'(255) : r[CH_W-1:0];
      if (cur.rows == '0) begin
        s = SUM_W'(px);
      end else begin
        if (cur.full_win) s = SUM_W'(s - SUM_W'(old));
        s = SUM_W'(s + SUM_W'(px));
      end
      sum_new[(NUM_CH-1-ch)*SUM_W +: SUM_W] = s;
    end
    res.red_out   = res_ch[0];
    res.green_out = res_ch[1];
    res.blue_out  = res_ch[2];
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      hist[{cur.ptr, cur.col}] <= cur.pix;
      sums[cur.col]            <= sum_new;
    end
  end

  // result queue
  assign empty     = (oq_count == '0);
  assign oq_pop    = pop && !empty;
  assign pixel_out = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (res_push) oq[oq_wr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (res_push) oq_wr <= OQ_AW'(oq_wr + OQ_AW'(1));
      if (oq_pop)   oq_rd <= OQ_AW'(oq_rd + OQ_AW'(1));
      oq_count <= (OQ_AW+1)'(oq_count + (OQ_AW+1)'(res_push) - (OQ_AW+1)'(oq_pop));
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("result queue overflow");
  a_read_to_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_DIV && div_busy == '1)
    else $error("dividers not started after read");
  a_push_space: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (oq_space || oq_pop))
    else $error("result pushed into full queue");

endmodule
`default_nettype wire

// ===== hw/rtl/vertical_motion_blur.sv =====
// Top level of the vertical motion blur: APB registers, front end, task queue,
// back end. Depends on vmb_pkg, vmb_front, vmb_taskq, vmb_back.
`default_nettype none
// Vertical causal box blur on an RGB raster stream. Each output channel is
// half the pixel plus half the truncated mean of the same column over up to
// blur_amount rows above; the top row of a frame gives the pixel halved.
// Both sides look like queues: push/full for pixels in, empty/pop for
// results out, one result per pixel, in order. The back end handles one pixel
// at a time: it pops the task and reads the stores, starts the dividers,
// runs the bit-serial divider (one quotient bit per cycle, three channels
// side by side) until all are done, and then writes back the line history
// and column sums; that divider sets the rate. The front end counts position
// and classifies up to four pixels ahead, so push is free while the back
// end divides. No clearing pass after reset: the stores start undefined
// and are written before use.
// Change image_width or blur_amount only between frames while idle.
module vertical_motion_blur (
  input  logic                             clk,
  input  logic                             rst,
  // pixel beats in
  input  logic                             push,
  output logic                             full,
  input  vmb_pkg::in_item_t                pixel_in,
  // result beats out
  output logic                             empty,
  input  logic                             pop,
  output vmb_pkg::out_item_t               pixel_out,
  // APB register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [vmb_pkg::APB_AW-1:0]       paddr,
  input  logic [vmb_pkg::APB_DW-1:0]       pwdata,
  output logic [vmb_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);
  import vmb_pkg::*;

  logic [WIDTH_REG_W-1:0] image_width;
  logic [BLUR_REG_W-1:0]  blur_amount;
  logic                   wr_en;
  logic [APB_AW-3:0]      reg_idx;
  logic                   take;
  task_t                  task_item;
  task_t                  tq_data;
  logic                   tq_full, tq_empty, tq_pop;

  // registers: word index from paddr, bytes within the word ignored
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_RST;
      blur_amount <= BLUR_AMOUNT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IMAGE_WIDTH: image_width <= pwdata[WIDTH_REG_W-1:0];
        REG_BLUR_AMOUNT: blur_amount <= pwdata[BLUR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_IMAGE_WIDTH: prdata = APB_DW'(image_width);
      REG_BLUR_AMOUNT: prdata = APB_DW'(blur_amount);
      default:         prdata = '0;
    endcase
  end

  // a pixel beat is taken whenever the task queue has room
  assign full = tq_full;
  assign take = push && !tq_full;

  vmb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .pixel       (pixel_in),
    .image_width (image_width),
    .blur_amount (blur_amount),
    .task_item   (task_item)
  );

  vmb_taskq u_taskq (
    .clk     (clk),
    .rst     (rst),
    .push    (take),
    .wr_data (task_item),
    .pop     (tq_pop),
    .rd_data (tq_data),
    .full    (tq_full),
    .empty   (tq_empty)
  );

  vmb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tq_empty  (tq_empty),
    .tq_data   (tq_data),
    .tq_pop    (tq_pop),
    .pop       (pop),
    .empty     (empty),
    .pixel_out (pixel_out)
  );

endmodule
`default_nettype wire
